// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty bodies when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define MBT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define MBT_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MBT_ASSERT(lbl, clk, rstn, prop, msg)
`define MBT_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ===== src/mbt_pkg.sv =====
// ---------------------------------------------------------------------------
// mbt_pkg
// Shared types, constants and arithmetic helpers for the MLP trainer.
// ---------------------------------------------------------------------------
package mbt_pkg;

  localparam int MAX_FEATURES = 8;
  localparam int MAX_HIDDEN   = 4;

  // Weight RAM map: w_in_hidden, bias_hidden, bias_out, w_hidden_out
  localparam int BH_BASE   = MAX_FEATURES * MAX_HIDDEN;
  localparam int BO_ADDR   = BH_BASE + MAX_HIDDEN;
  localparam int WHO_BASE  = BO_ADDR + 1;
  localparam int RAM_DEPTH = WHO_BASE + MAX_HIDDEN;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  localparam int FI_W  = $clog2(MAX_FEATURES);
  localparam int HI_W  = $clog2(MAX_HIDDEN);
  localparam int E_MAX = (MAX_FEATURES > MAX_HIDDEN) ? MAX_FEATURES : MAX_HIDDEN;
  localparam int E_W   = $clog2(E_MAX + 1);

  localparam int A_W    = 39;
  localparam int B_W    = 18;
  localparam int PROD_W = A_W + B_W;
  localparam int ACC_W  = 40;
  localparam int Z_W    = 28;

  localparam logic [15:0] SEED_DEFAULT = 16'd44257;
  localparam logic [15:0] LFSR_TAPS    = 16'hB400;
  localparam logic [15:0] LR_RESET     = 16'd6554;

  typedef logic signed [15:0] q12_t;

  typedef enum logic [1:0] {
    CFG_LEARN_RATE  = 2'd0,
    CFG_INPUTS_USED = 2'd1,
    CFG_HIDDEN_USED = 2'd2,
    CFG_INIT_SEED   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        action;
    q12_t        feat_0;
    q12_t        feat_1;
    q12_t        feat_2;
    q12_t        feat_3;
    q12_t        feat_4;
    q12_t        feat_5;
    q12_t        feat_6;
    q12_t        feat_7;
    logic [15:0] goal;
  } in_item_t;

  typedef struct packed {
    logic [15:0] prediction;
    logic [15:0] sq_error;
    logic        error_valid;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       data;
  } ram_wr_t;

  typedef enum logic [4:0] {
    S_FILL,
    S_IDLE,
    S_FH_RD, S_FH_MUL, S_FH_ACC, S_FH_SIG,
    S_FO_RD, S_FO_MUL, S_FO_ACC, S_FO_SIG,
    S_ERR, S_SQ, S_SQ2,
    S_DH_RD, S_DH_M1, S_DH_M2, S_DH_M3, S_DH_M4,
    S_UT, S_UT2, S_U_RD, S_U_MUL, S_U_WR,
    S_DONE
  } mbt_state_e;

  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    return (s >> 1) ^ (s[0] ? LFSR_TAPS : 16'd0);
  endfunction

  // Piecewise-linear sigmoid, Q.12 in, Q0.16 out
  function automatic logic [15:0] sigmoid_q16(input logic signed [Z_W-1:0] z);
    logic [Z_W-1:0] a;
    logic [17:0]    y;
    a = z[Z_W-1] ? (~z + Z_W'(1)) : z;
    if (a >= Z_W'(20480))     y = 18'd65536;
    else if (a >= Z_W'(9728)) y = 18'(a >> 1) + 18'd55296;
    else if (a >= Z_W'(4096)) y = 18'(a << 1) + 18'd40960;
    else                      y = 18'(a << 2) + 18'd32768;
    if (z[Z_W-1]) y = 18'd65536 - y;
    return (y > 18'd65535) ? 16'hFFFF : y[15:0];
  endfunction

  function automatic q12_t sat16(input logic signed [25:0] v);
    if (v > 26'sd32767)  return 16'sh7FFF;
    if (v < -26'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

// ===== src/mbt_ram.sv =====
// ---------------------------------------------------------------------------
// mbt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mbt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 41
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/mbt_mul.sv =====
// ---------------------------------------------------------------------------
// mbt_mul
// Shared signed multiplier with registered product.
// ---------------------------------------------------------------------------
module mbt_mul (
  input  logic                              clk_i,
  input  logic signed [mbt_pkg::A_W-1:0]    a_i,
  input  logic signed [mbt_pkg::B_W-1:0]    b_i,
  output logic signed [mbt_pkg::PROD_W-1:0] p_o
);

  logic signed [mbt_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= mbt_pkg::PROD_W'(a_i) * mbt_pkg::PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== src/mbt_fill.sv =====
// ---------------------------------------------------------------------------
// mbt_fill
// Weight initialisation sweep: LFSR weights, then cleared biases.
// ---------------------------------------------------------------------------
module mbt_fill (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [15:0]          seed_i,
  output logic                 busy_o,
  output mbt_pkg::ram_wr_t     wr_o
);

  logic                        busy_q;
  logic                        bias_q;
  logic [mbt_pkg::E_W-1:0]     i_q;
  logic [mbt_pkg::HI_W-1:0]    j_q;
  logic [15:0]                 lfsr_q;
  logic [15:0]                 lfsr_d;

  assign lfsr_d = mbt_pkg::lfsr_step(lfsr_q);

  always_comb begin
    wr_o.we = busy_q;
    if (bias_q) begin
      wr_o.addr = mbt_pkg::ADDR_W'(mbt_pkg::BH_BASE) + mbt_pkg::ADDR_W'(i_q);
      wr_o.data = 16'd0;
    end else begin
      if (i_q == mbt_pkg::E_W'(mbt_pkg::MAX_FEATURES)) begin
        wr_o.addr = mbt_pkg::ADDR_W'(mbt_pkg::WHO_BASE) + mbt_pkg::ADDR_W'(j_q);
      end else begin
        wr_o.addr = mbt_pkg::ADDR_W'(i_q) * mbt_pkg::ADDR_W'(mbt_pkg::MAX_HIDDEN)
                    + mbt_pkg::ADDR_W'(j_q);
      end
      wr_o.data = {4'd0, lfsr_d[15:4]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      bias_q <= 1'b0;
      i_q    <= '0;
      j_q    <= '0;
      lfsr_q <= mbt_pkg::SEED_DEFAULT;
    end else if (start_i) begin
      busy_q <= 1'b1;
      bias_q <= 1'b0;
      i_q    <= '0;
      j_q    <= '0;
      lfsr_q <= (seed_i == 16'd0) ? mbt_pkg::SEED_DEFAULT : seed_i;
    end else if (busy_q) begin
      if (!bias_q) begin
        lfsr_q <= lfsr_d;
        if (i_q == mbt_pkg::E_W'(mbt_pkg::MAX_FEATURES)) begin
          i_q <= '0;
          if (j_q == mbt_pkg::HI_W'(mbt_pkg::MAX_HIDDEN - 1)) begin
            bias_q <= 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end else begin
          i_q <= i_q + 1'b1;
        end
      end else begin
        if (i_q == mbt_pkg::E_W'(mbt_pkg::MAX_HIDDEN)) begin
          busy_q <= 1'b0;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;

endmodule

// ===== src/mlp_backprop_trainer_core.sv =====
// ---------------------------------------------------------------------------
// mlp_backprop_trainer_core
// Two-layer perceptron, sigmoid units, online backpropagation on one RAM.
// ---------------------------------------------------------------------------
// Each weight access is a read / multiply / accumulate-or-write step on the
// single weight RAM and the shared multiplier.
// Reset, and every init_seed write, runs a fill of the weight RAM (LFSR
// weights, zero biases); no transfer is taken while a fill started from reset
// or from the idle state runs.
`include "assert_macros.svh"

module mlp_backprop_trainer_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mbt_pkg::in_item_t   in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mbt_pkg::out_item_t  out_o
);

  // -------------------------------------------------------------------------
  // Configuration
  // -------------------------------------------------------------------------
  logic [15:0] lr_q;
  logic [3:0]  nf_cfg_q;
  logic [2:0]  nh_cfg_q;
  logic        seed_wr;

  assign seed_wr = cfg_we_i && (mbt_pkg::cfg_idx_e'(cfg_idx_i) == mbt_pkg::CFG_INIT_SEED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q     <= mbt_pkg::LR_RESET;
      nf_cfg_q <= 4'(mbt_pkg::MAX_FEATURES);
      nh_cfg_q <= 3'(mbt_pkg::MAX_HIDDEN);
    end else if (cfg_we_i) begin
      unique case (mbt_pkg::cfg_idx_e'(cfg_idx_i))
        mbt_pkg::CFG_LEARN_RATE:  lr_q     <= cfg_data_i;
        mbt_pkg::CFG_INPUTS_USED: nf_cfg_q <= cfg_data_i[3:0];
        mbt_pkg::CFG_HIDDEN_USED: nh_cfg_q <= cfg_data_i[2:0];
        mbt_pkg::CFG_INIT_SEED:   ;  // handled by the fill unit
        default:                  ;
      endcase
    end
  end

  // Counts clamp to [1, max]
  logic [mbt_pkg::E_W-1:0] nf, nh;

  always_comb begin
    if (nf_cfg_q == 4'd0)                           nf = mbt_pkg::E_W'(1);
    else if (nf_cfg_q > 4'(mbt_pkg::MAX_FEATURES))  nf = mbt_pkg::E_W'(mbt_pkg::MAX_FEATURES);
    else                                            nf = mbt_pkg::E_W'(nf_cfg_q);
    if (nh_cfg_q == 3'd0)                           nh = mbt_pkg::E_W'(1);
    else if (nh_cfg_q > 3'(mbt_pkg::MAX_HIDDEN))    nh = mbt_pkg::E_W'(mbt_pkg::MAX_HIDDEN);
    else                                            nh = mbt_pkg::E_W'(nh_cfg_q);
  end

  // -------------------------------------------------------------------------
  // Fill unit, weight RAM, multiplier
  // -------------------------------------------------------------------------
  logic                          fill_busy;
  mbt_pkg::ram_wr_t              fill_wr;
  logic                          seq_we;
  logic [mbt_pkg::ADDR_W-1:0]    seq_waddr;
  logic [15:0]                   seq_wdata;
  logic [mbt_pkg::ADDR_W-1:0]    ram_raddr;
  logic [15:0]                   ram_rdata;
  logic signed [mbt_pkg::A_W-1:0]    mul_a;
  logic signed [mbt_pkg::B_W-1:0]    mul_b;
  logic signed [mbt_pkg::PROD_W-1:0] p_q;

  mbt_fill u_fill (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (seed_wr),
    .seed_i  (cfg_data_i),
    .busy_o  (fill_busy),
    .wr_o    (fill_wr)
  );

  mbt_ram #(
    .WIDTH (16),
    .DEPTH (mbt_pkg::RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (fill_busy ? fill_wr.we   : seq_we),
    .waddr_i (fill_busy ? fill_wr.addr : seq_waddr),
    .wdata_i (fill_busy ? fill_wr.data : seq_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mbt_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p_q)
  );

  // -------------------------------------------------------------------------
  // Sequencer state and working registers
  // -------------------------------------------------------------------------
  mbt_pkg::mbt_state_e state_q, state_d;

  logic [mbt_pkg::E_W-1:0]  e_q;     // element within a unit
  logic [mbt_pkg::HI_W-1:0] j_q;     // hidden unit
  logic                     upd_out_q;
  logic                     act_q;
  logic [15:0]              goal_q;
  mbt_pkg::q12_t            x_q  [mbt_pkg::MAX_FEATURES];
  logic [15:0]              h_q  [mbt_pkg::MAX_HIDDEN];
  logic signed [20:0]       dh_q [mbt_pkg::MAX_HIDDEN];
  logic signed [mbt_pkg::ACC_W-1:0] acc_q;
  logic [15:0]              pred_q;
  logic [15:0]              sq_q;
  logic signed [16:0]       d_q;
  logic signed [20:0]       s_q;
  logic signed [37:0]       t_q;
  mbt_pkg::q12_t            w_q;
  logic                     out_valid_q;
  mbt_pkg::out_item_t       out_q;

  logic bias_h, bias_o, last_j, out_free, accept;
  mbt_pkg::q12_t x_sel;
  logic [15:0]   h_e, h_j;

  assign bias_h   = (e_q == nf);
  assign bias_o   = (e_q == nh);
  assign last_j   = ((mbt_pkg::E_W'(j_q) + mbt_pkg::E_W'(1)) == nh);
  assign x_sel    = x_q[e_q[mbt_pkg::FI_W-1:0]];
  assign h_e      = h_q[e_q[mbt_pkg::HI_W-1:0]];
  assign h_j      = h_q[j_q];
  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;

  // Addresses
  logic [mbt_pkg::ADDR_W-1:0] addr_wih, addr_bh, addr_bo, addr_who_e, addr_who_j, upd_addr;

  assign addr_wih   = mbt_pkg::ADDR_W'(e_q[mbt_pkg::FI_W-1:0])
                      * mbt_pkg::ADDR_W'(mbt_pkg::MAX_HIDDEN) + mbt_pkg::ADDR_W'(j_q);
  assign addr_bh    = mbt_pkg::ADDR_W'(mbt_pkg::BH_BASE) + mbt_pkg::ADDR_W'(j_q);
  assign addr_bo    = mbt_pkg::ADDR_W'(mbt_pkg::BO_ADDR);
  assign addr_who_e = mbt_pkg::ADDR_W'(mbt_pkg::WHO_BASE) + mbt_pkg::ADDR_W'(e_q);
  assign addr_who_j = mbt_pkg::ADDR_W'(mbt_pkg::WHO_BASE) + mbt_pkg::ADDR_W'(j_q);

  always_comb begin
    if (upd_out_q) upd_addr = bias_o ? addr_bo : addr_who_e;
    else           upd_addr = bias_h ? addr_bh : addr_wih;
  end

  // Rounding: add half an LSB, then arithmetic shift (ties toward +inf)
  logic signed [mbt_pkg::ACC_W-1:0]  acc_r12, acc_r16;
  logic signed [mbt_pkg::PROD_W-1:0] p_r12, p_r16, p_r31, p_r35;
  logic signed [25:0]                upd_sum;

  assign acc_r12 = acc_q + mbt_pkg::ACC_W'(64'sd2048);
  assign acc_r16 = acc_q + mbt_pkg::ACC_W'(64'sd32768);
  assign p_r12   = p_q + mbt_pkg::PROD_W'(64'sd2048);
  assign p_r16   = p_q + mbt_pkg::PROD_W'(64'sd32768);
  assign p_r31   = p_q + mbt_pkg::PROD_W'(64'sd2147483648);
  assign p_r35   = p_q + mbt_pkg::PROD_W'(64'sd34359738368);
  assign upd_sum = 26'(w_q) + (upd_out_q ? 26'($signed(p_r35[56:36]))
                                         : 26'($signed(p_r31[56:32])));

  // -------------------------------------------------------------------------
  // Next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbt_pkg::S_FILL:   if (!fill_busy) state_d = mbt_pkg::S_IDLE;
      mbt_pkg::S_IDLE: begin
        if (seed_wr)     state_d = mbt_pkg::S_FILL;
        else if (accept) state_d = mbt_pkg::S_FH_RD;
      end
      mbt_pkg::S_FH_RD:  state_d = mbt_pkg::S_FH_MUL;
      mbt_pkg::S_FH_MUL: state_d = mbt_pkg::S_FH_ACC;
      mbt_pkg::S_FH_ACC: state_d = bias_h ? mbt_pkg::S_FH_SIG : mbt_pkg::S_FH_RD;
      mbt_pkg::S_FH_SIG: state_d = last_j ? mbt_pkg::S_FO_RD : mbt_pkg::S_FH_RD;
      mbt_pkg::S_FO_RD:  state_d = mbt_pkg::S_FO_MUL;
      mbt_pkg::S_FO_MUL: state_d = mbt_pkg::S_FO_ACC;
      mbt_pkg::S_FO_ACC: state_d = bias_o ? mbt_pkg::S_FO_SIG : mbt_pkg::S_FO_RD;
      mbt_pkg::S_FO_SIG: state_d = act_q ? mbt_pkg::S_ERR : mbt_pkg::S_DONE;
      mbt_pkg::S_ERR:    state_d = mbt_pkg::S_SQ;
      mbt_pkg::S_SQ:     state_d = mbt_pkg::S_SQ2;
      mbt_pkg::S_SQ2:    state_d = mbt_pkg::S_DH_RD;
      mbt_pkg::S_DH_RD:  state_d = mbt_pkg::S_DH_M1;
      mbt_pkg::S_DH_M1:  state_d = mbt_pkg::S_DH_M2;
      mbt_pkg::S_DH_M2:  state_d = mbt_pkg::S_DH_M3;
      mbt_pkg::S_DH_M3:  state_d = mbt_pkg::S_DH_M4;
      mbt_pkg::S_DH_M4:  state_d = last_j ? mbt_pkg::S_UT : mbt_pkg::S_DH_RD;
      mbt_pkg::S_UT:     state_d = mbt_pkg::S_UT2;
      mbt_pkg::S_UT2:    state_d = mbt_pkg::S_U_RD;
      mbt_pkg::S_U_RD:   state_d = mbt_pkg::S_U_MUL;
      mbt_pkg::S_U_MUL:  state_d = mbt_pkg::S_U_WR;
      mbt_pkg::S_U_WR: begin
        if (upd_out_q) state_d = bias_o ? mbt_pkg::S_DONE : mbt_pkg::S_U_RD;
        else           state_d = bias_h ? mbt_pkg::S_UT : mbt_pkg::S_U_RD;
      end
      mbt_pkg::S_DONE:   if (out_free) state_d = mbt_pkg::S_IDLE;
      default:           state_d = mbt_pkg::S_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // RAM and multiplier controls
  // -------------------------------------------------------------------------
  always_comb begin
    ram_raddr = '0;
    seq_we    = 1'b0;
    seq_waddr = upd_addr;
    seq_wdata = mbt_pkg::sat16(upd_sum);
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      mbt_pkg::S_FH_RD:  ram_raddr = bias_h ? addr_bh : addr_wih;
      mbt_pkg::S_FH_MUL: begin
        mul_a = bias_h ? mbt_pkg::A_W'(64'sd4096) : mbt_pkg::A_W'(x_sel);
        mul_b = mbt_pkg::B_W'($signed(ram_rdata));
      end
      mbt_pkg::S_FO_RD:  ram_raddr = bias_o ? addr_bo : addr_who_e;
      mbt_pkg::S_FO_MUL: begin
        mul_a = bias_o ? mbt_pkg::A_W'(64'sd65536) : $signed({23'd0, h_e});
        mul_b = mbt_pkg::B_W'($signed(ram_rdata));
      end
      mbt_pkg::S_SQ: begin
        mul_a = mbt_pkg::A_W'(d_q);
        mul_b = mbt_pkg::B_W'(d_q);
      end
      mbt_pkg::S_DH_RD:  ram_raddr = addr_who_j;
      mbt_pkg::S_DH_M1: begin
        mul_a = mbt_pkg::A_W'(d_q);
        mul_b = mbt_pkg::B_W'($signed(ram_rdata));
      end
      mbt_pkg::S_DH_M2: begin
        mul_a = $signed({23'd0, h_j});
        mul_b = $signed(18'd65536 - {2'd0, h_j});
      end
      mbt_pkg::S_DH_M3: begin
        mul_a = mbt_pkg::A_W'(s_q);
        mul_b = $signed({2'd0, p_q[31:16]});
      end
      mbt_pkg::S_UT: begin
        mul_a = upd_out_q ? mbt_pkg::A_W'(d_q) : mbt_pkg::A_W'(dh_q[j_q]);
        mul_b = $signed({2'd0, lr_q});
      end
      mbt_pkg::S_U_RD:   ram_raddr = upd_addr;
      mbt_pkg::S_U_MUL: begin
        mul_a = mbt_pkg::A_W'(t_q);
        if (upd_out_q) mul_b = bias_o ? mbt_pkg::B_W'(64'sd65536) : $signed({2'd0, h_e});
        else           mul_b = bias_h ? mbt_pkg::B_W'(64'sd4096) : mbt_pkg::B_W'(x_sel);
      end
      mbt_pkg::S_U_WR:   seq_we = 1'b1;
      default:           ;
    endcase
  end

  // -------------------------------------------------------------------------
  // Control registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbt_pkg::S_FILL;
      e_q         <= '0;
      j_q         <= '0;
      upd_out_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        mbt_pkg::S_IDLE: begin
          if (accept) begin
            e_q       <= '0;
            j_q       <= '0;
            upd_out_q <= 1'b0;
          end
        end
        mbt_pkg::S_FH_ACC, mbt_pkg::S_FO_ACC: begin
          if (state_d == mbt_pkg::S_FH_RD || state_d == mbt_pkg::S_FO_RD) e_q <= e_q + 1'b1;
        end
        mbt_pkg::S_FH_SIG: begin
          e_q <= '0;
          j_q <= last_j ? '0 : j_q + 1'b1;
        end
        mbt_pkg::S_FO_SIG: begin
          e_q <= '0;
          j_q <= '0;
        end
        mbt_pkg::S_DH_M4:  j_q <= last_j ? '0 : j_q + 1'b1;
        mbt_pkg::S_UT2:    e_q <= '0;
        mbt_pkg::S_U_WR: begin
          if (upd_out_q ? bias_o : bias_h) begin
            e_q <= '0;
            if (!upd_out_q) begin
              if (last_j) begin
                upd_out_q <= 1'b1;
                j_q       <= '0;
              end else begin
                j_q <= j_q + 1'b1;
              end
            end
          end else begin
            e_q <= e_q + 1'b1;
          end
        end
        mbt_pkg::S_DONE:   if (out_free) out_valid_q <= 1'b1;
        default:           ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Datapath registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      mbt_pkg::S_IDLE: begin
        if (accept) begin
          act_q  <= in_i.action;
          goal_q <= in_i.goal;
          x_q[0] <= in_i.feat_0;
          x_q[1] <= in_i.feat_1;
          x_q[2] <= in_i.feat_2;
          x_q[3] <= in_i.feat_3;
          x_q[4] <= in_i.feat_4;
          x_q[5] <= in_i.feat_5;
          x_q[6] <= in_i.feat_6;
          x_q[7] <= in_i.feat_7;
        end
      end
      mbt_pkg::S_FH_ACC, mbt_pkg::S_FO_ACC: begin
        acc_q <= ((e_q == '0) ? '0 : acc_q) + p_q[mbt_pkg::ACC_W-1:0];
      end
      mbt_pkg::S_FH_SIG: h_q[j_q] <= mbt_pkg::sigmoid_q16($signed(acc_r12[39:12]));
      mbt_pkg::S_FO_SIG: pred_q <= mbt_pkg::sigmoid_q16(28'($signed(acc_r16[39:16])));
      mbt_pkg::S_ERR:    d_q <= $signed({1'b0, goal_q}) - $signed({1'b0, pred_q});
      mbt_pkg::S_SQ2:    sq_q <= p_q[32:17];
      mbt_pkg::S_DH_M2:  s_q <= p_r12[32:12];
      mbt_pkg::S_DH_M4:  dh_q[j_q] <= p_r16[36:16];
      mbt_pkg::S_UT2:    t_q <= p_q[37:0];
      mbt_pkg::S_U_MUL:  w_q <= ram_rdata;
      mbt_pkg::S_DONE: begin
        if (out_free) begin
          out_q.prediction  <= pred_q;
          out_q.sq_error    <= act_q ? sq_q : 16'd0;
          out_q.error_valid <= act_q;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == mbt_pkg::S_IDLE) && !seed_wr;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `MBT_ASSERT_RST(a_rst_no_ready, clk_i, !rst_ni |=> !in_ready_o, "ready during reset")
  `MBT_ASSERT(a_fill_no_ready, clk_i, rst_ni, fill_busy |-> !in_ready_o, "ready during fill")
  `MBT_ASSERT(a_accept_starts, clk_i, rst_ni, accept |=> (state_q == mbt_pkg::S_FH_RD), "no start")
  `MBT_ASSERT(a_wr_no_fill, clk_i, rst_ni, seq_we |-> !fill_busy, "update during fill")
  `MBT_ASSERT(a_infer_no_err, clk_i, rst_ni, (out_valid_o && !out_o.error_valid) |-> (out_o.sq_error == 16'd0), "error on inference")

endmodule
